@@ src/mccdp_pkg.sv @@
// Shared constants and types of the minimum coin change engine.
package mccdp_pkg;

   // Default largest amount kept in the table.
   localparam int MAX_AMOUNT_DEFAULT = 4096;

   // Width of every word field on the request and response channels.
   localparam int FIELD_W = 13;

   // Largest count the response field can carry.
   localparam logic [FIELD_W-1:0] FIELD_MAX = 13'h1FFF;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SWEEP  = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_LOOKUP = 5'b01000,
      ST_ANSWER = 5'b10000
   } state_type;

endpackage

@@ src/mccdp_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
module mccdp_ram #(
   parameter int WIDTH = mccdp_pkg::FIELD_W + 1,
   parameter int DEPTH = mccdp_pkg::MAX_AMOUNT_DEFAULT + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   // Read returns the contents before a same-cycle write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

@@ src/min_coin_change_dp_core.sv @@
// Top level of the minimum coin change engine: sequencer, sweep pipeline and table RAM.
// Throughput: the sweep rewrites one table entry per cycle; no new coin word is accepted
//   until the sweep and drain are done and, after a last coin, the lookup and the answer,
//   which waits out any response stall; the response word is registered as it is left.
// Reset: synchronous, active high; clears the sequencer and valid flags and arms a new
//   problem. The table RAM is not cleared: the first coin's sweep rewrites every entry.
module min_coin_change_dp_core #(
   parameter int MAX_AMOUNT = mccdp_pkg::MAX_AMOUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel: one coin word
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mccdp_pkg::FIELD_W-1:0] req_coin_value,
   input  logic                          req_last_coin,
   input  logic [mccdp_pkg::FIELD_W-1:0] req_target_amount,
   // response channel: one answer word per problem
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mccdp_pkg::FIELD_W-1:0] rsp_min_coins,
   output logic                          rsp_reachable
);

   // Address and count widths follow the table depth; a count never exceeds its amount.
   localparam int ADDR_W  = $clog2(MAX_AMOUNT + 1);
   localparam int CNT_W   = ADDR_W;
   localparam int ENTRY_W = CNT_W + 1;
   // Comparison width wide enough for both the input fields and the table range.
   localparam int CMP_W   = (ADDR_W > mccdp_pkg::FIELD_W) ? ADDR_W : mccdp_pkg::FIELD_W;

   // Table entry: reachable flag on top of the count.
   typedef struct packed {
      logic             reach;
      logic [CNT_W-1:0] cnt;
   } entry_type;

   mccdp_pkg::state_type state_ff, state_in;

   // Per-word context captured at accept.
   logic [ADDR_W-1:0] coin_ff, coin_in;
   logic              coin_ok_ff, coin_ok_in;
   logic              last_ff, last_in;
   logic [ADDR_W-1:0] tgt_addr_ff, tgt_addr_in;
   logic              tgt_ok_ff, tgt_ok_in;
   logic              new_problem_ff, new_problem_in;
   logic              sweep_first_ff, sweep_first_in;

   // Sweep issue position.
   logic [ADDR_W-1:0] idx_ff, idx_in;

   // Compute stage: the entry whose reads were issued last cycle.
   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_idx_ff;
   logic              s1_has_below_ff;
   logic              s1_fwd_ff;
   entry_type         last_wr_ff;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mccdp_pkg::FIELD_W-1:0] rsp_min_coins_ff, rsp_min_coins_in;
   logic                          rsp_reachable_ff, rsp_reachable_in;

   logic              accept;
   logic              issue_has_below;
   logic              issue_fwd;
   logic [ADDR_W-1:0] below_addr;
   logic [ADDR_W-1:0] rd_a_addr;
   logic [ENTRY_W-1:0] rd_a_raw, rd_b_raw;
   entry_type         rd_a_entry, rd_b_entry;
   entry_type         old_entry, below_entry, new_entry;
   logic [CNT_W-1:0]  cand_cnt;
   logic              rsp_load;
   logic [CMP_W-1:0]  coin_ext, tgt_ext, ans_cnt_ext;

   assign req_stall = (state_ff != mccdp_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign coin_ext = CMP_W'(req_coin_value);
   assign tgt_ext  = CMP_W'(req_target_amount);

   // Issue side: the entry coin_value below the swept amount, when it exists.
   assign issue_has_below = coin_ok_ff && (idx_ff >= coin_ff);
   assign below_addr      = idx_ff - coin_ff;
   // The entry written this cycle is read back stale; forward it next cycle.
   assign issue_fwd       = s1_valid_ff && issue_has_below && (below_addr == s1_idx_ff);

   // Hold the target address on port A once the sweep is done.
   assign rd_a_addr = (state_ff == mccdp_pkg::ST_LOOKUP || state_ff == mccdp_pkg::ST_ANSWER)
                      ? tgt_addr_ff : idx_ff;

   mccdp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_AMOUNT + 1)
   ) u_table (
      .clock     (clock),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_idx_ff),
      .wr_data   (new_entry),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_raw),
      .rd_b_addr (below_addr),
      .rd_b_data (rd_b_raw)
   );

   assign rd_a_entry = rd_a_raw;
   assign rd_b_entry = rd_b_raw;

   // Compute stage: relax one entry against the entry one coin below.
   always_comb begin
      // First sweep of a problem sees the restarted table: only amount zero is reachable.
      if (sweep_first_ff) begin
         old_entry.reach = (s1_idx_ff == '0);
         old_entry.cnt   = '0;
      end else begin
         old_entry = rd_a_entry;
      end
      below_entry = s1_fwd_ff ? last_wr_ff : rd_b_entry;
      cand_cnt    = below_entry.cnt + CNT_W'(1);
      new_entry   = old_entry;
      if (s1_has_below_ff && below_entry.reach &&
          (!old_entry.reach || cand_cnt < old_entry.cnt)) begin
         new_entry.reach = 1'b1;
         new_entry.cnt   = cand_cnt;
      end
   end

   // Response load: saturate the count to the field width.
   assign rsp_load    = (state_ff == mccdp_pkg::ST_ANSWER) && (!rsp_valid_ff || !rsp_stall);
   assign ans_cnt_ext = CMP_W'(rd_a_entry.cnt);

   always_comb begin
      state_in         = state_ff;
      coin_in          = coin_ff;
      coin_ok_in       = coin_ok_ff;
      last_in          = last_ff;
      tgt_addr_in      = tgt_addr_ff;
      tgt_ok_in        = tgt_ok_ff;
      new_problem_in   = new_problem_ff;
      sweep_first_in   = sweep_first_ff;
      idx_in           = idx_ff;
      s1_valid_in      = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_min_coins_in = rsp_min_coins_ff;
      rsp_reachable_in = rsp_reachable_ff;

      unique case (state_ff)
         mccdp_pkg::ST_IDLE: begin
            if (accept) begin
               // Capture the word; a coin out of range rewrites entries unchanged.
               coin_in        = coin_ext[ADDR_W-1:0];
               coin_ok_in     = (coin_ext != '0) && (coin_ext <= CMP_W'(MAX_AMOUNT));
               last_in        = req_last_coin;
               tgt_addr_in    = tgt_ext[ADDR_W-1:0];
               tgt_ok_in      = (tgt_ext <= CMP_W'(MAX_AMOUNT));
               sweep_first_in = new_problem_ff;
               new_problem_in = req_last_coin;
               idx_in         = '0;
               state_in       = mccdp_pkg::ST_SWEEP;
            end
         end
         mccdp_pkg::ST_SWEEP: begin
            // Advance one amount per cycle over the whole table.
            s1_valid_in = 1'b1;
            if (idx_ff == ADDR_W'(MAX_AMOUNT)) begin
               state_in = mccdp_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         mccdp_pkg::ST_DRAIN: begin
            state_in = last_ff ? mccdp_pkg::ST_LOOKUP : mccdp_pkg::ST_IDLE;
         end
         mccdp_pkg::ST_LOOKUP: begin
            state_in = mccdp_pkg::ST_ANSWER;
         end
         mccdp_pkg::ST_ANSWER: begin
            // Hold here until the response register is free.
            if (rsp_load) begin
               rsp_valid_in     = 1'b1;
               rsp_reachable_in = tgt_ok_ff && rd_a_entry.reach;
               if (!(tgt_ok_ff && rd_a_entry.reach)) begin
                  rsp_min_coins_in = '0;
               end else if (ans_cnt_ext > CMP_W'(mccdp_pkg::FIELD_MAX)) begin
                  rsp_min_coins_in = mccdp_pkg::FIELD_MAX;
               end else begin
                  rsp_min_coins_in = ans_cnt_ext[mccdp_pkg::FIELD_W-1:0];
               end
               state_in = mccdp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mccdp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mccdp_pkg::ST_IDLE;
         new_problem_ff <= 1'b1;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         new_problem_ff <= new_problem_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coin_ff          <= coin_in;
      coin_ok_ff       <= coin_ok_in;
      last_ff          <= last_in;
      tgt_addr_ff      <= tgt_addr_in;
      tgt_ok_ff        <= tgt_ok_in;
      sweep_first_ff   <= sweep_first_in;
      idx_ff           <= idx_in;
      s1_idx_ff        <= idx_ff;
      s1_has_below_ff  <= issue_has_below;
      s1_fwd_ff        <= issue_fwd;
      rsp_min_coins_ff <= rsp_min_coins_in;
      rsp_reachable_ff <= rsp_reachable_in;
      if (s1_valid_ff) begin
         last_wr_ff <= new_entry;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_coins = rsp_min_coins_ff;
   assign rsp_reachable = rsp_reachable_ff;

   // Forwarding only arises when the coin reads the entry just behind it.
   a_fwd_unit_coin: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> (coin_ff == ADDR_W'(1)))
      else $error("forwarding used with a coin other than one");

   // Table writes come only from the sweep pipeline.
   a_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == mccdp_pkg::ST_SWEEP || state_ff == mccdp_pkg::ST_DRAIN))
      else $error("table write outside the sweep");

   // A reachable amount never needs more coins than the amount itself.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && new_entry.reach) |-> (new_entry.cnt <= s1_idx_ff))
      else $error("coin count exceeds its amount");

   // A new response word is loaded only at the end of a problem.
   a_rsp_from_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(state_ff == mccdp_pkg::ST_ANSWER && last_ff))
      else $error("response word without a finished problem");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the minimum coin change engine.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIELD_W = mccdp_pkg::FIELD_W;
   localparam logic [FIELD_W-1:0] FIELD_MAX = mccdp_pkg::FIELD_MAX;
   localparam int AMOUNT_TOP = mccdp_pkg::MAX_AMOUNT_DEFAULT;
   // No accept may be seen for at most one sweep plus the longest sender gap;
   // allow many times that before calling the run hung.
   localparam int WATCHDOG_LIMIT = 10 * (2 * AMOUNT_TOP + 32);
   localparam int RANDOM_WORDS = 120;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [FIELD_W-1:0] min_coins;
      logic               reachable;
   } answer_type;

   // Scoreboard: predicts the answer of each problem from the coin words seen
   // on the request side and checks the answer words in order.
   class coin_change_scoreboard_type;
      localparam int TOP = mccdp_pkg::MAX_AMOUNT_DEFAULT;

      int unsigned best_cnt [TOP+1];
      bit          reach_ok [TOP+1];
      bit          fresh_problem;
      answer_type  answers_due [$];
      int          mismatches;

      function new();
         restart_table();
         fresh_problem = 1'b1;
         mismatches    = 0;
      endfunction

      function void restart_table();
         for (int a = 0; a <= TOP; a++) begin
            best_cnt[a] = 0;
            reach_ok[a] = 1'b0;
         end
         reach_ok[0] = 1'b1;
      endfunction

      // Unbounded knapsack sweep in rising order, so a coin may be reused.
      function void sweep_coin(int unsigned coin);
         int unsigned cand;
         if (coin == 0 || coin > TOP)
            return;
         for (int a = coin; a <= TOP; a++) begin
            if (reach_ok[a-coin]) begin
               cand = best_cnt[a-coin] + 1;
               if (!reach_ok[a] || cand < best_cnt[a]) begin
                  best_cnt[a] = cand;
                  reach_ok[a] = 1'b1;
               end
            end
         end
      endfunction

      function void note_coin(logic [FIELD_W-1:0] coin, logic last,
                              logic [FIELD_W-1:0] target);
         answer_type ans;
         if (fresh_problem) begin
            restart_table();
            fresh_problem = 1'b0;
         end
         sweep_coin(coin);
         if (!last)
            return;
         fresh_problem = 1'b1;
         if (target <= TOP && reach_ok[target]) begin
            ans.min_coins = (best_cnt[target] > FIELD_MAX) ? FIELD_MAX
                                                           : best_cnt[target][FIELD_W-1:0];
            ans.reachable = 1'b1;
         end else begin
            ans.min_coins = '0;
            ans.reachable = 1'b0;
         end
         answers_due.push_back(ans);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t ERROR: %s", $realtime, msg);
      endfunction

      function void check_answer(logic [FIELD_W-1:0] min_coins, logic reachable);
         answer_type want;
         if (answers_due.size() == 0) begin
            flag($sformatf("unexpected answer word min_coins=%0d reachable=%0b",
                           min_coins, reachable));
            return;
         end
         want = answers_due.pop_front();
         if (min_coins !== want.min_coins)
            flag($sformatf("min_coins expected %0d actual %0d", want.min_coins, min_coins));
         if (reachable !== want.reachable)
            flag($sformatf("reachable expected %0b actual %0b", want.reachable, reachable));
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [FIELD_W-1:0] req_coin_value = '0;
   logic               req_last_coin = 1'b0;
   logic [FIELD_W-1:0] req_target_amount = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [FIELD_W-1:0] rsp_min_coins;
   logic               rsp_reachable;

   // Set while both sides are to run with no idling at all.
   bit                 calm = 1'b0;
   int                 idle_cycles = 0;

   coin_change_scoreboard_type sb = new();

   min_coin_change_dp_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_coin_value    (req_coin_value),
      .req_last_coin     (req_last_coin),
      .req_target_amount (req_target_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_min_coins     (rsp_min_coins),
      .rsp_reachable     (rsp_reachable)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the answer channel on about one cycle in five, except when calm.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 19);
   end

   // Sample both channels at the edge; the block updates its outputs with
   // nonblocking assignments, so these reads see the pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_coin(req_coin_value, req_last_coin, req_target_amount);
         if (rsp_valid && !rsp_stall)
            sb.check_answer(rsp_min_coins, rsp_reachable);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: end the run if no word moves for too long.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Drive one coin word and hold it until accepted. Call at a clock edge;
   // returns at the edge of the accept. A random gap, short or as long as a
   // whole sweep, lets valid rise at any phase of the block's work.
   task automatic send_coin(input logic [FIELD_W-1:0] coin, input logic last,
                            input logic [FIELD_W-1:0] target);
      int unsigned gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 19)
         gap = ($urandom_range(1) != 0) ? $urandom_range(8, 1)
                                        : $urandom_range(AMOUNT_TOP + 12, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_coin_value    <= coin;
      req_last_coin     <= last;
      req_target_amount <= target;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and hold off until every pending answer has come back.
   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Pick a coin: mostly small values that make dense tables, some across the
   // full range, and a little noise (zero coin, coin above the table).
   function automatic logic [FIELD_W-1:0] pick_coin();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6)
         return '0;
      if (r < 12)
         return FIELD_W'($urandom_range(8191, AMOUNT_TOP + 1));
      if (r < 75)
         return FIELD_W'($urandom_range(64, 1));
      return FIELD_W'($urandom_range(AMOUNT_TOP, 1));
   endfunction

   function automatic logic [FIELD_W-1:0] pick_target();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)
         return FIELD_W'($urandom_range(8191, AMOUNT_TOP + 1));
      if (r < 70)
         return FIELD_W'($urandom_range(300, 0));
      return FIELD_W'($urandom_range(AMOUNT_TOP, 0));
   endfunction

   initial begin
      int words_sent;
      int coins_in_problem;
      words_sent = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      // Smallest coin to the top amount: the largest possible count.
      send_coin(13'd1, 1'b1, 13'd4096);
      // Largest in-range coin, hit and just missed.
      send_coin(13'd4096, 1'b1, 13'd4096);
      send_coin(13'd4096, 1'b1, 13'd4095);
      // Target zero needs zero coins.
      send_coin(13'd1, 1'b1, 13'd0);
      // Zero coin restarts the table but changes nothing.
      send_coin(13'd0, 1'b1, 13'd0);
      send_coin(13'd0, 1'b1, 13'd5);
      // Coin and target above the table, all bits set.
      send_coin(13'h1FFF, 1'b1, 13'h1FFF);
      // Two coins that cannot make the target.
      send_coin(13'd3, 1'b0, 13'd0);
      send_coin(13'd5, 1'b1, 13'd7);
      // Classic three-coin problem.
      send_coin(13'd1, 1'b0, 13'd0);
      send_coin(13'd2, 1'b0, 13'd0);
      send_coin(13'd5, 1'b1, 13'd11);
      // Mixed coins to the top amount.
      send_coin(13'd2, 1'b0, 13'h1555);
      send_coin(13'd3, 1'b0, 13'h0AAA);
      send_coin(13'd7, 1'b1, 13'd4096);
      // Oversized coin in the middle, then a target just above the table.
      send_coin(13'd5000, 1'b0, 13'd0);
      send_coin(13'd3, 1'b1, 13'd4097);
      // Ignore the target of a non-last word; oversized last coin.
      send_coin(13'd1, 1'b0, 13'h1FFF);
      send_coin(13'd4097, 1'b1, 13'd4096);

      drain_answers();

      // Random part: well-formed problems of one to four coins.
      while (words_sent < RANDOM_WORDS) begin
         coins_in_problem = $urandom_range(4, 1);
         calm = (words_sent >= 50 && words_sent < 85);
         for (int k = 0; k < coins_in_problem; k++) begin
            if (k == coins_in_problem - 1)
               send_coin(pick_coin(), 1'b1, pick_target());
            else
               send_coin(pick_coin(), 1'b0, FIELD_W'($urandom_range(8191)));
            words_sent++;
         end
         if (words_sent >= 100 && words_sent < 105)
            drain_answers();
      end
      calm = 1'b0;

      // Drain: wait for every answer, then keep watching for stray answer words.
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (AMOUNT_TOP + 8) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
src/mccdp_pkg.sv
src/mccdp_ram.sv
src/min_coin_change_dp_core.sv
verif/tb_top.sv
